[hdl/pink_noise_filter_assert.svh]
// Assertion macros used by the pink noise filter RTL.
`ifndef PINK_NOISE_FILTER_ASSERT_SVH
`define PINK_NOISE_FILTER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define PNF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pink_noise_filter: assertion failed");

// Consequence in the cycle after the condition.
`define PNF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pink_noise_filter: assertion failed");

`endif

[hdl/pnf_pkg.sv]
// Constants, types and coefficient table of the pink noise filter.
package pnf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int COEF_FRAC   = 20;
    localparam int COEF_W      = COEF_FRAC + 1;
    localparam int STATE_BITS  = 40;
    localparam int OUT_BITS    = 20;
    localparam int NUM_POLES   = 6;

    // Eight 40-bit terms are summed, so three guard bits suffice.
    localparam int SUM_W      = STATE_BITS + 3;
    localparam int ACC_W      = SUM_W + COEF_W;
    localparam int IN_SHIFT   = COEF_FRAC - FRAC_BITS;
    localparam int OUT_SHIFT  = FRAC_BITS + COEF_FRAC;
    localparam int OUT_RAW_W  = ACC_W - OUT_SHIFT;
    localparam int NUM_OPS    = 2 * NUM_POLES + 3;
    localparam int OP_W       = $clog2(NUM_OPS);
    localparam int CNT_W      = $clog2(COEF_W);

    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic signed [STATE_BITS-1:0] state_word_t;
    typedef logic signed [OUT_BITS-1:0]   out_word_t;
    typedef logic [OP_W-1:0]              op_t;

    // Operation codes after the pole sections (2*i is pole i, 2*i+1 its gain).
    localparam op_t OP_DIRECT = op_t'(2 * NUM_POLES);
    localparam op_t OP_HELD   = op_t'(2 * NUM_POLES + 1);
    localparam op_t OP_SCALE  = op_t'(2 * NUM_POLES + 2);

    // Signed Q1.20 coefficient used by each operation.
    function automatic coef_t op_coef(input op_t op);
        coef_t c;
        case (op)
            op_t'(0):  c = 21'sd1047381;
            op_t'(1):  c = 21'sd58215;
            op_t'(2):  c = 21'sd1041572;
            op_t'(3):  c = 21'sd78723;
            op_t'(4):  c = 21'sd1016070;
            op_t'(5):  c = 21'sd161326;
            op_t'(6):  c = 21'sd908591;
            op_t'(7):  c = 21'sd325568;
            op_t'(8):  c = 21'sd576717;
            op_t'(9):  c = 21'sd558841;
            op_t'(10): c = -21'sd798595;
            op_t'(11): c = -21'sd17719;
            OP_DIRECT: c = 21'sd562246;
            OP_HELD:   c = 21'sd121557;
            OP_SCALE:  c = 21'sd209715;
            default:   c = '0;
        endcase
        return c;
    endfunction

    // Saturate a value with two extra bits to the state width.
    function automatic state_word_t sat_state(input logic [STATE_BITS+1:0] v);
        logic [2:0] top;
        top = v[STATE_BITS+1:STATE_BITS-1];
        if (&top || ~|top) begin
            return v[STATE_BITS-1:0];
        end
        return {v[STATE_BITS+1], {(STATE_BITS-1){~v[STATE_BITS+1]}}};
    endfunction

    // Saturate the scaled output to the result width.
    function automatic out_word_t sat_out(input logic [OUT_RAW_W-1:0] v);
        logic [OUT_RAW_W-OUT_BITS:0] top;
        top = v[OUT_RAW_W-1:OUT_BITS-1];
        if (&top || ~|top) begin
            return v[OUT_BITS-1:0];
        end
        return {v[OUT_RAW_W-1], {(OUT_BITS-1){~v[OUT_RAW_W-1]}}};
    endfunction

endpackage

[hdl/pink_noise_filter.sv]
// Pink noise shaping filter: six one-pole sections plus direct and delayed taps.
//
// Input transactions carry one signed 16-bit sample on s_sample_in (s_valid/s_ready).
// Each accepted sample produces exactly one signed 20-bit result on m_pink_out
// (m_valid/m_ready), in order.
//
// All fifteen products (six pole terms, six gain terms, the direct and delayed
// taps and the final 0.2 scale) go through one shift-and-add multiplier that
// consumes one coefficient bit per cycle, MSB first; each product is followed
// by a step that rounds, saturates and accumulates it. That serial multiplier
// sets the rate: the block takes no new sample until the result of the previous
// one has been handed to the output register.
//
// The result sits in an output register. While the receiver stalls the block
// still accepts and processes the next sample; only the hand-off of a newer
// result waits until the output register has been emptied.
//
// Reset (aresetn low, synchronous) clears all six section states, the delayed
// tap and the output valid flag; the block is ready the cycle after reset.
`include "pink_noise_filter_assert.svh"

module pink_noise_filter
    import pnf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_BITS-1:0]    m_pink_out
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_POST, ST_DONE} state_t;

    localparam logic [ACC_W-1:0] ONE      = ACC_W'(1);
    localparam logic [ACC_W-1:0] HALF_IN  = ONE << (IN_SHIFT - 1);
    localparam logic [ACC_W-1:0] HALF_CF  = ONE << (COEF_FRAC - 1);
    localparam logic [ACC_W-1:0] HALF_OUT = ONE << (OUT_SHIFT - 1);

    // Control and datapath registers.
    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    coef_t                     coef_sh_reg, coef_sh_next;
    logic [SUM_W-1:0]          mcand_reg, mcand_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0]    x_reg, x_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [STATE_BITS:0]       pt_reg, pt_next;
    state_word_t               held_reg, held_next;
    out_word_t                 y_reg, y_next;
    logic                      m_valid_reg, m_valid_next;
    out_word_t                 m_pink_out_reg, m_pink_out_next;

    // Section states, one entry per pole.
    state_word_t               pole_sums_reg [NUM_POLES];
    logic                      pole_we;
    state_word_t               pole_wdata;

    // Combinational helpers.
    logic [ACC_W-1:0]          mcand_ext;
    logic [ACC_W-1:0]          prod_term;
    logic [ACC_W-1:0]          half_sel;
    logic [ACC_W-1:0]          rnd_sum;
    logic [STATE_BITS+1:0]     in_term;
    logic [STATE_BITS+1:0]     st_raw;
    state_word_t               st_sat;
    op_t                       op_inc;
    logic [SUM_W-1:0]          op_mcand;
    logic                      is_pole_op;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_pink_out = m_pink_out_reg;

    assign is_pole_op = (op_reg < OP_DIRECT) && !op_reg[0];
    assign op_inc     = op_reg + op_t'(1);

    // Multiplier step: the sign bit of the coefficient carries negative weight.
    assign mcand_ext = {{(ACC_W-SUM_W){mcand_reg[SUM_W-1]}}, mcand_reg};
    always_comb begin
        if (!coef_sh_reg[COEF_W-1]) begin
            prod_term = '0;
        end else if (cnt_reg == '0) begin
            prod_term = -mcand_ext;
        end else begin
            prod_term = mcand_ext;
        end
    end

    // Round to nearest at the binary point that belongs to the finished product.
    always_comb begin
        if (is_pole_op) begin
            half_sel = HALF_CF;
        end else if (op_reg == OP_SCALE) begin
            half_sel = HALF_OUT;
        end else begin
            half_sel = HALF_IN;
        end
    end
    assign rnd_sum = acc_reg + half_sel;
    assign in_term = rnd_sum[IN_SHIFT +: STATE_BITS+2];
    assign st_raw  = {pt_reg[STATE_BITS], pt_reg} + in_term;
    assign st_sat  = sat_state(st_raw);

    // Multiplicand of the operation that follows the current one.
    always_comb begin
        if (op_inc == OP_SCALE) begin
            op_mcand = sum_reg;
        end else if (op_inc < OP_DIRECT && !op_inc[0]) begin
            op_mcand = {{(SUM_W-STATE_BITS){pole_sums_reg[op_inc[OP_W-1:1]][STATE_BITS-1]}},
                        pole_sums_reg[op_inc[OP_W-1:1]]};
        end else begin
            op_mcand = {{(SUM_W-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        coef_sh_next    = coef_sh_reg;
        mcand_next      = mcand_reg;
        acc_next        = acc_reg;
        x_next          = x_reg;
        sum_next        = sum_reg;
        pt_next         = pt_reg;
        held_next       = held_reg;
        y_next          = y_reg;
        m_valid_next    = m_valid_reg;
        m_pink_out_next = m_pink_out_reg;
        pole_we         = 1'b0;
        pole_wdata      = st_sat;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // The delayed tap enters the sum with its value from the last sample.
                    x_next       = s_sample_in;
                    sum_next     = {{(SUM_W-STATE_BITS){held_reg[STATE_BITS-1]}}, held_reg};
                    op_next      = '0;
                    mcand_next   = {{(SUM_W-STATE_BITS){pole_sums_reg[0][STATE_BITS-1]}},
                                    pole_sums_reg[0]};
                    coef_sh_next = op_coef('0);
                    cnt_next     = '0;
                    acc_next     = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next     = {acc_reg[ACC_W-2:0], 1'b0} + prod_term;
                coef_sh_next = {coef_sh_reg[COEF_W-2:0], 1'b0};
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(COEF_W - 1)) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (is_pole_op) begin
                    pt_next = rnd_sum[COEF_FRAC +: STATE_BITS+1];
                end else if (op_reg < OP_DIRECT) begin
                    pole_we  = 1'b1;
                    sum_next = sum_reg + {{(SUM_W-STATE_BITS){st_sat[STATE_BITS-1]}}, st_sat};
                end else if (op_reg == OP_DIRECT) begin
                    sum_next = sum_reg + {in_term[STATE_BITS+1], in_term};
                end else if (op_reg == OP_HELD) begin
                    held_next = sat_state(in_term);
                end else begin
                    y_next = sat_out(rnd_sum[OUT_SHIFT +: OUT_RAW_W]);
                end

                if (op_reg == OP_SCALE) begin
                    state_next = ST_DONE;
                end else begin
                    op_next      = op_inc;
                    mcand_next   = op_mcand;
                    coef_sh_next = op_coef(op_inc);
                    cnt_next     = '0;
                    acc_next     = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_pink_out_next = y_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
            for (int i = 0; i < NUM_POLES; i++) begin
                pole_sums_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            coef_sh_reg    <= coef_sh_next;
            mcand_reg      <= mcand_next;
            acc_reg        <= acc_next;
            x_reg          <= x_next;
            sum_reg        <= sum_next;
            pt_reg         <= pt_next;
            held_reg       <= held_next;
            y_reg          <= y_next;
            m_valid_reg    <= m_valid_next;
            m_pink_out_reg <= m_pink_out_next;
            if (pole_we) begin
                pole_sums_reg[op_reg[OP_W-1:1]] <= pole_wdata;
            end
        end
    end

    // An accepted sample starts the sequence at the first pole section.
    `PNF_ASSERT_NEXT(a_accept_starts, s_valid && s_ready, !s_ready && op_reg == '0)
    // The result is only handed off once the final scale product is done.
    `PNF_ASSERT_SAME(a_done_after_scale, state_reg == ST_DONE, op_reg == OP_SCALE)
    // A new result appears only from the hand-off state.
    `PNF_ASSERT_SAME(a_valid_from_done, $rose(m_valid_reg), $past(state_reg) == ST_DONE)
    // The bit counter never runs past the coefficient width.
    `PNF_ASSERT_SAME(a_cnt_range, state_reg == ST_MUL, cnt_reg < CNT_W'(COEF_W))

endmodule
